// ===== rtl/valseg_pkg.sv =====
// Shared widths, register indexes, state types and the crossing request
// bundle for the variable-area lobe segmenter. No dependencies.
package valseg_pkg;

  localparam int POSITION_FRACTION_BITS = 8;

  localparam int OFFSET_W   = 16;
  localparam int MAG_W      = 16;
  localparam int STEP_W     = 8;
  localparam int START_W    = 16;
  localparam int POS_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // crossing fraction is at most step << fraction bits
  localparam int QUO_W  = STEP_W + POSITION_FRACTION_BITS;
  localparam int PROD_W = MAG_W + STEP_W;
  localparam int DEN_W  = MAG_W + 1;
  localparam int CNT_W  = $clog2(QUO_W);

  localparam logic [CFG_IDX_W-1:0] CFG_FILL_POSITIVE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_POSITION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_STEP    = 2'd2;

  typedef enum logic [1:0] {
    CX_IDLE,
    CX_MUL,
    CX_DIV
  } cx_state_t;

  typedef enum logic [1:0] {
    SEG_IDLE,
    SEG_WAIT,
    SEG_EMIT
  } seg_state_t;

  typedef struct packed {
    logic [MAG_W-1:0]  ma;
    logic [MAG_W-1:0]  mb;
    logic [STEP_W-1:0] step;
  } cross_req_t;

endpackage

// ===== rtl/valseg_crossdiv.sv =====
// Bit-serial crossing fraction unit: (step << F) * ma / (ma + mb).
// Shift-add multiply, one step bit per cycle, then restoring divide, one
// quotient bit per cycle. Depends on valseg_pkg.
module valseg_crossdiv (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  valseg_pkg::cross_req_t      req,
  output logic                        done,
  output logic [valseg_pkg::QUO_W-1:0] frac
);

  valseg_pkg::cx_state_t state, state_next;

  logic [valseg_pkg::CNT_W-1:0]  cnt;
  logic [valseg_pkg::PROD_W-1:0] mcand;
  logic [valseg_pkg::STEP_W-1:0] mplier;
  logic [valseg_pkg::PROD_W-1:0] prod;
  logic [valseg_pkg::PROD_W-1:0] prod_next;
  logic [valseg_pkg::DEN_W-1:0]  den;
  logic [valseg_pkg::DEN_W-1:0]  rem;
  logic [valseg_pkg::DEN_W-1:0]  rem_next;
  logic [valseg_pkg::DEN_W:0]    trial;
  logic [valseg_pkg::QUO_W-1:0]  numsh;
  logic [valseg_pkg::QUO_W-1:0]  quo;
  logic                          fits;
  logic                          mul_last;
  logic                          div_last;

  assign prod_next = prod + (mplier[0] ? mcand : '0);
  assign trial     = {rem, numsh[valseg_pkg::QUO_W-1]};
  assign fits      = trial >= {1'b0, den};
  assign rem_next  = fits ? valseg_pkg::DEN_W'(trial - {1'b0, den})
                          : valseg_pkg::DEN_W'(trial);
  assign mul_last  = (state == valseg_pkg::CX_MUL) &&
                     (cnt == valseg_pkg::CNT_W'(valseg_pkg::STEP_W - 1));
  assign div_last  = (state == valseg_pkg::CX_DIV) &&
                     (cnt == valseg_pkg::CNT_W'(valseg_pkg::QUO_W - 1));
  assign frac      = quo;

  always_comb begin
    state_next = state;
    case (state)
      valseg_pkg::CX_IDLE: if (start) state_next = valseg_pkg::CX_MUL;
      valseg_pkg::CX_MUL:  if (mul_last) state_next = valseg_pkg::CX_DIV;
      valseg_pkg::CX_DIV:  if (div_last) state_next = valseg_pkg::CX_IDLE;
      default:             state_next = valseg_pkg::CX_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= valseg_pkg::CX_IDLE;
      cnt   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= div_last;
      if (state == valseg_pkg::CX_IDLE || mul_last) begin
        cnt <= '0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == valseg_pkg::CX_IDLE && start) begin
      mcand  <= valseg_pkg::PROD_W'(req.ma);
      mplier <= req.step;
      prod   <= '0;
      den    <= valseg_pkg::DEN_W'(req.ma) + valseg_pkg::DEN_W'(req.mb);
    end else if (state == valseg_pkg::CX_MUL) begin
      prod   <= prod_next;
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
      if (mul_last) begin
        // top bits of the product seed the remainder, the rest stream in
        rem   <= valseg_pkg::DEN_W'(prod_next[valseg_pkg::PROD_W-1:valseg_pkg::STEP_W]);
        numsh <= valseg_pkg::QUO_W'(prod_next[valseg_pkg::STEP_W-1:0])
                 << valseg_pkg::POSITION_FRACTION_BITS;
        quo   <= '0;
      end
    end else if (state == valseg_pkg::CX_DIV) begin
      rem   <= rem_next;
      numsh <= numsh << 1;
      quo   <= {quo[valseg_pkg::QUO_W-2:0], fits};
    end
  end

endmodule

// ===== rtl/variable_area_lobe_segmenter.sv =====
// Variable-area lobe segmenter, top level. Depends on valseg_pkg, valseg_crossdiv.
// A request that needs no zero crossing goes straight to EMIT; one that does waits
//   in WAIT while valseg_crossdiv multiplies and divides, then goes to EMIT.
// sample_stall holds new samples until every vertex (0..3) of the item has been
//   emitted; a sample that yields no vertex does not stall.
// Reset: synchronous; control and configuration registers take their reset values, no lobe open.
module variable_area_lobe_segmenter (
  input  logic                              clk,
  input  logic                              rst,
  // configuration
  input  logic                              cfg_write,
  input  logic [valseg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [valseg_pkg::CFG_DATA_W-1:0] cfg_data,
  // sample requests
  input  logic                              sample_valid,
  output logic                              sample_stall,
  input  logic signed [valseg_pkg::OFFSET_W-1:0] sample_offset,
  input  logic                              last_sample,
  // vertex results
  output logic                              vertex_valid,
  input  logic                              vertex_stall,
  output logic signed [valseg_pkg::OFFSET_W-1:0] vertex_offset,
  output logic [valseg_pkg::POS_W-1:0]      vertex_position,
  output logic                              opens_lobe,
  output logic                              closes_lobe,
  output logic                              last_of_item
);

  localparam int F = valseg_pkg::POSITION_FRACTION_BITS;

  function automatic logic [valseg_pkg::POS_W-1:0] pos_sat_add(
    input logic [valseg_pkg::POS_W-1:0] a,
    input logic [valseg_pkg::POS_W-1:0] b
  );
    logic [valseg_pkg::POS_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[valseg_pkg::POS_W] ? '1 : s[valseg_pkg::POS_W-1:0];
  endfunction

  // magnitude of a two's complement offset; the most negative code maps to 0x8000
  function automatic logic [valseg_pkg::MAG_W-1:0] mag(
    input logic [valseg_pkg::OFFSET_W-1:0] v
  );
    return v[valseg_pkg::OFFSET_W-1] ? valseg_pkg::MAG_W'(-v) : valseg_pkg::MAG_W'(v);
  endfunction

  // configuration registers
  logic                           fill_positive;
  logic [valseg_pkg::START_W-1:0] start_position;
  logic [valseg_pkg::STEP_W-1:0]  sample_step;

  // trace state
  logic [valseg_pkg::OFFSET_W-1:0] previous_offset;
  logic [valseg_pkg::POS_W-1:0]    current_position;
  logic                            lobe_open;
  logic                            first_of_trace;

  // per-request work registers
  logic [valseg_pkg::OFFSET_W-1:0] item_offset;
  logic [valseg_pkg::POS_W-1:0]    item_pos;
  logic [valseg_pkg::POS_W-1:0]    base_pos;
  logic [valseg_pkg::POS_W-1:0]    cross_pos;
  logic                            pend_open;
  logic                            pend_sample;
  logic                            pend_close;
  logic                            open_cross;
  logic                            close_cross;

  valseg_pkg::seg_state_t state, state_next;

  logic                           accept;
  logic                           on_side;
  logic [valseg_pkg::POS_W-1:0]   start_q;
  logic [valseg_pkg::POS_W-1:0]   pos_now;
  logic                           need_open;
  logic                           need_close_cross;
  logic                           need_cross;
  logic                           any_result;
  logic                           out_free;
  logic                           emit;
  logic                           emit_last;
  valseg_pkg::cross_req_t         req;
  logic                           cx_done;
  logic [valseg_pkg::QUO_W-1:0]   cx_frac;

  assign sample_stall = (state != valseg_pkg::SEG_IDLE);
  assign accept       = sample_valid && !sample_stall;

  // zero is never on the fill side
  assign on_side = fill_positive
                   ? (!sample_offset[valseg_pkg::OFFSET_W-1] && (sample_offset != '0))
                   : sample_offset[valseg_pkg::OFFSET_W-1];

  assign start_q = valseg_pkg::POS_W'(start_position) << F;
  assign pos_now = first_of_trace
                   ? start_q
                   : pos_sat_add(current_position, valseg_pkg::POS_W'(sample_step) << F);

  assign need_open        = on_side && !lobe_open;
  assign need_close_cross = !on_side && lobe_open;
  // the first sample of a trace opens at its own position, no interpolation
  assign need_cross       = (need_open && !first_of_trace) || need_close_cross;
  assign any_result       = on_side || lobe_open;

  assign req.ma   = mag(previous_offset);
  assign req.mb   = mag(sample_offset);
  assign req.step = sample_step;

  valseg_crossdiv u_crossdiv (
    .clk   (clk),
    .rst   (rst),
    .start (accept && need_cross),
    .req   (req),
    .done  (cx_done),
    .frac  (cx_frac)
  );

  // output register frees when empty or being taken
  assign out_free  = !vertex_valid || !vertex_stall;
  assign emit      = (state == valseg_pkg::SEG_EMIT) && out_free;
  // vertices go out in order: opening, sample, closing
  assign emit_last = pend_open ? !(pend_sample || pend_close)
                   : pend_sample ? !pend_close
                   : 1'b1;

  always_comb begin
    state_next = state;
    case (state)
      valseg_pkg::SEG_IDLE: begin
        if (accept && any_result) begin
          state_next = need_cross ? valseg_pkg::SEG_WAIT : valseg_pkg::SEG_EMIT;
        end
      end
      valseg_pkg::SEG_WAIT: if (cx_done) state_next = valseg_pkg::SEG_EMIT;
      valseg_pkg::SEG_EMIT: if (emit && emit_last) state_next = valseg_pkg::SEG_IDLE;
      default:              state_next = valseg_pkg::SEG_IDLE;
    endcase
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= valseg_pkg::SEG_IDLE;
      fill_positive    <= 1'b1;
      start_position   <= '0;
      sample_step      <= valseg_pkg::STEP_W'(1);
      previous_offset  <= '0;
      current_position <= '0;
      lobe_open        <= 1'b0;
      first_of_trace   <= 1'b1;
      vertex_valid     <= 1'b0;
      pend_open        <= 1'b0;
      pend_sample      <= 1'b0;
      pend_close       <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        case (cfg_index)
          valseg_pkg::CFG_FILL_POSITIVE:  fill_positive  <= cfg_data[0];
          valseg_pkg::CFG_START_POSITION: start_position <= cfg_data[valseg_pkg::START_W-1:0];
          valseg_pkg::CFG_SAMPLE_STEP:    sample_step    <= cfg_data[valseg_pkg::STEP_W-1:0];
          default: ;
        endcase
      end

      if (accept) begin
        // trace state advances at once; the crossing keeps its own copies
        pend_open   <= need_open;
        pend_sample <= on_side;
        pend_close  <= (on_side && last_sample) || need_close_cross;
        lobe_open   <= on_side && !last_sample;
        if (last_sample) begin
          first_of_trace   <= 1'b1;
          previous_offset  <= '0;
          current_position <= start_q;
        end else begin
          first_of_trace   <= 1'b0;
          previous_offset  <= sample_offset;
          current_position <= pos_now;
        end
      end else if (emit) begin
        if (pend_open) begin
          pend_open <= 1'b0;
        end else if (pend_sample) begin
          pend_sample <= 1'b0;
        end else begin
          pend_close <= 1'b0;
        end
      end

      if (emit) begin
        vertex_valid <= 1'b1;
      end else if (!vertex_stall) begin
        vertex_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      item_offset <= sample_offset;
      item_pos    <= pos_now;
      base_pos    <= current_position;
      open_cross  <= need_open && !first_of_trace;
      close_cross <= need_close_cross;
    end
    if (state == valseg_pkg::SEG_WAIT && cx_done) begin
      cross_pos <= pos_sat_add(base_pos, valseg_pkg::POS_W'(cx_frac));
    end
    if (emit) begin
      last_of_item <= emit_last;
      if (pend_open) begin
        vertex_offset   <= '0;
        vertex_position <= open_cross ? cross_pos : item_pos;
        opens_lobe      <= 1'b1;
        closes_lobe     <= 1'b0;
      end else if (pend_sample) begin
        vertex_offset   <= item_offset;
        vertex_position <= item_pos;
        opens_lobe      <= 1'b0;
        closes_lobe     <= 1'b0;
      end else begin
        vertex_offset   <= '0;
        vertex_position <= close_cross ? cross_pos : item_pos;
        opens_lobe      <= 1'b0;
        closes_lobe     <= 1'b1;
      end
    end
  end

endmodule
